// ===== design/mrlc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrlc_pkg
// Shared types, record codes and the first-character lookup for the line
// classifier.
// ----------------------------------------------------------------------------
package mrlc_pkg;

    // Character codes
    localparam logic [7:0] CHAR_COMMENT = 8'h40;  // '@'
    localparam logic [7:0] CHAR_BLOCK   = 8'h26;  // '&'
    localparam logic [7:0] CHAR_ATTR    = 8'h24;  // '$'
    localparam logic [7:0] CHAR_END     = 8'h2F;  // '/'

    // Header window and count ceiling
    localparam logic [3:0] HEADER_LINES = 4'd12;
    localparam logic [3:0] COUNT_MAX    = 4'd13;

    // Record codes
    localparam logic [4:0] RT_UNKNOWN     = 5'd0;
    localparam logic [4:0] RT_COMMENT     = 5'd1;
    localparam logic [4:0] RT_BLOCK       = 5'd2;
    localparam logic [4:0] RT_HEADER_BASE = 5'd2;
    localparam logic [4:0] RT_HEADER_LAST = 5'd14;
    localparam logic [4:0] RT_EMPTY       = 5'd15;
    localparam logic [4:0] RT_ENDTEXT     = 5'd16;
    localparam logic [4:0] RT_NOTE        = 5'd17;
    localparam logic [4:0] RT_CHORD       = 5'd18;
    localparam logic [4:0] RT_CUE         = 5'd19;
    localparam logic [4:0] RT_GRACE       = 5'd20;
    localparam logic [4:0] RT_PRINT       = 5'd21;
    localparam logic [4:0] RT_SOUND       = 5'd22;
    localparam logic [4:0] RT_END         = 5'd23;
    localparam logic [4:0] RT_APPEND      = 5'd24;
    localparam logic [4:0] RT_BACKSPACE   = 5'd25;
    localparam logic [4:0] RT_FIGURED     = 5'd26;
    localparam logic [4:0] RT_INVISIBLE   = 5'd27;
    localparam logic [4:0] RT_MEASURE     = 5'd28;
    localparam logic [4:0] RT_REST        = 5'd29;
    localparam logic [4:0] RT_DIRECTION   = 5'd30;
    localparam logic [4:0] RT_ATTRIBUTES  = 5'd31;

    // One line descriptor
    typedef struct packed {
        logic       file_start;
        logic       line_empty;
        logic [7:0] first_char;
    } line_item_t;

    // Kept state between lines
    typedef struct packed {
        logic       comment_open;
        logic [3:0] header_count;
        logic       attributes_seen;
        logic       end_seen;
    } cls_state_t;

    // Record type from the first character of a body line
    function automatic logic [4:0] type_of_char(input logic [7:0] c);
        logic [4:0] t;
        begin
            t = RT_UNKNOWN;
            if (c >= 8'h41 && c <= 8'h47) begin
                t = RT_NOTE;
            end else begin
                unique case (c)
                    8'h20:    t = RT_CHORD;
                    8'h63:    t = RT_CUE;
                    8'h67:    t = RT_GRACE;
                    8'h50:    t = RT_PRINT;
                    8'h53:    t = RT_SOUND;
                    CHAR_END: t = RT_END;
                    8'h61:    t = RT_APPEND;
                    8'h62:    t = RT_BACKSPACE;
                    8'h66:    t = RT_FIGURED;
                    8'h69:    t = RT_INVISIBLE;
                    8'h6D:    t = RT_MEASURE;
                    8'h72:    t = RT_REST;
                    8'h2A:    t = RT_DIRECTION;
                    CHAR_ATTR: t = RT_ATTRIBUTES;
                    default:  t = RT_UNKNOWN;
                endcase
            end
            return t;
        end
    endfunction

endpackage

// ===== design/mrlc_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrlc_in_stage
// Input register: captures one line descriptor word and holds it until the
// classifier stage takes it.
// ----------------------------------------------------------------------------
module mrlc_in_stage
    import mrlc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] first_char
    input  logic [1:0] s_tuser,   // [0] file_start, [1] line_empty
    output logic       item_valid,
    output line_item_t item,
    input  logic       item_take
);

    logic       valid_reg, valid_next;
    line_item_t item_reg, item_next;

    // Accept when empty or when the held word leaves this cycle
    assign s_tready = !valid_reg || item_take;

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
            if (s_tvalid) begin
                item_next.file_start = s_tuser[0];
                item_next.line_empty = s_tuser[1];
                item_next.first_char = s_tdata;
            end
        end
    end

    // Control register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload register
    always_ff @(posedge aclk) begin
        item_reg <= item_next;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== design/mrlc_classifier.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrlc_classifier
// Classifies the held line, updates the kept comment, header and section
// flags, and registers the record type for the output channel.
// ----------------------------------------------------------------------------
module mrlc_classifier
    import mrlc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       item_valid,
    input  line_item_t item,
    output logic       item_take,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [4:0] record_type, [7:5] zero
);

    cls_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic [4:0] rtype_reg, rtype_next;

    cls_state_t cur;
    cls_state_t upd;
    logic [4:0] rtype;
    logic [3:0] cnt_inc;
    logic [4:0] char_type;
    logic       is_char_attr;
    logic       is_char_end;

    // Take the held word when the result register is free or draining
    assign item_take = item_valid && (!out_valid_reg || m_tready);

    // Classify one line
    always_comb begin
        cur = item.file_start ? '0 : state_reg;
        upd = cur;
        is_char_attr = (item.first_char == CHAR_ATTR);
        is_char_end  = (item.first_char == CHAR_END);
        char_type    = type_of_char(item.first_char);
        cnt_inc      = (cur.header_count < COUNT_MAX) ?
                       (cur.header_count + 4'd1) : cur.header_count;
        rtype        = RT_UNKNOWN;
        priority if (!item.line_empty && item.first_char == CHAR_COMMENT) begin
            rtype = RT_COMMENT;
        end else if (!item.line_empty && item.first_char == CHAR_BLOCK) begin
            upd.comment_open = !cur.comment_open;
            rtype = RT_BLOCK;
        end else if (!item.line_empty && cur.comment_open) begin
            rtype = RT_BLOCK;
        end else begin
            upd.header_count = cnt_inc;
            priority if (cnt_inc <= HEADER_LINES) begin
                rtype = RT_HEADER_BASE + {1'b0, cnt_inc};
            end else if (item.line_empty) begin
                rtype = RT_EMPTY;
            end else if (!is_char_attr && !cur.attributes_seen) begin
                rtype = RT_HEADER_LAST;
            end else if (cur.end_seen && !is_char_end) begin
                rtype = RT_ENDTEXT;
            end else begin
                rtype = char_type;
                if (char_type == RT_END) begin
                    upd.end_seen = 1'b1;
                end
                if (char_type == RT_ATTRIBUTES) begin
                    upd.attributes_seen = 1'b1;
                end
            end
        end
    end

    // Advance state and result register
    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        rtype_next     = rtype_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (item_take) begin
            state_next     = upd;
            out_valid_next = 1'b1;
            rtype_next     = rtype;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload register
    always_ff @(posedge aclk) begin
        rtype_reg <= rtype_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, rtype_reg};

endmodule

// ===== design/music_record_line_classifier_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// music_record_line_classifier_top
// Types each line of a music notation text file from its first character,
// its emptiness and the comment, header and section flags kept per file.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                  | tuser
//  s_      | in  | [7:0] first_char       | [0] file_start, [1] line_empty
//  m_      | out | [4:0] record_type      | -
//
//  One word per cycle sustained while m_tready stays high; a word sits in the
//  input register after it is accepted and moves into the result register
//  when that register is free or draining, which raises m_tvalid.
//  The kept flags update in the same cycle that a word enters the result
//  register, so order is kept across any stall pattern.
//  Synchronous active-low reset clears the flags and both valid bits.
//  A stall on m_ backs up into the input register and then drops s_tready.
// ----------------------------------------------------------------------------
module music_record_line_classifier_top
    import mrlc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] first_char
    input  logic [1:0] s_tuser,   // [0] file_start, [1] line_empty
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [4:0] record_type, [7:5] zero
);

    logic       item_valid;
    logic       item_take;
    line_item_t item;

    mrlc_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    mrlc_classifier u_classifier (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams line descriptors into the music record line classifier and checks
// every record type against an in-bench classifier. The lines are mostly
// well-formed files: headers, comment blocks, an attributes line, body lines,
// an end mark and trailing text. Noise lines, missing sections and random
// file starts are mixed in. Both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;
    import mrlc_pkg::*;

    typedef struct {
        line_item_t line;
        bit         drain;  // hold this word until every record is back
    } queued_line_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;  // [7:0] first_char
    logic [1:0] s_tuser  = 2'b00;  // [0] file_start, [1] line_empty
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;           // [4:0] record_type, [7:5] zero

    queued_line_t line_queue[$];
    logic [4:0]   record_queue[$];

    // Classifier state kept across lines
    logic       in_block   = 1'b0;
    logic [3:0] line_count = 4'd0;
    logic       attr_seen  = 1'b0;
    logic       end_seen   = 1'b0;

    int    lines_sent      = 0;
    int    records_checked = 0;
    int    mismatch_count  = 0;
    int    file_count      = 0;
    bit    drain_next      = 1'b0;
    string body_chars      = "ABCDEFG cgPSabfimr*$";

    music_record_line_classifier_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Record type of a body line from its first byte
    function automatic logic [4:0] char_record(input logic [7:0] c);
        unique case (c)
            "A", "B", "C", "D", "E", "F", "G": return RT_NOTE;
            " ":       return RT_CHORD;
            "c":       return RT_CUE;
            "g":       return RT_GRACE;
            "P":       return RT_PRINT;
            "S":       return RT_SOUND;
            CHAR_END:  return RT_END;
            "a":       return RT_APPEND;
            "b":       return RT_BACKSPACE;
            "f":       return RT_FIGURED;
            "i":       return RT_INVISIBLE;
            "m":       return RT_MEASURE;
            "r":       return RT_REST;
            "*":       return RT_DIRECTION;
            CHAR_ATTR: return RT_ATTRIBUTES;
            default:   return RT_UNKNOWN;
        endcase
    endfunction

    // Classify one line and advance the kept state
    function automatic logic [4:0] predict_record(input line_item_t w);
        logic [4:0] t;
        if (w.file_start) begin
            in_block   = 1'b0;
            line_count = 4'd0;
            attr_seen  = 1'b0;
            end_seen   = 1'b0;
        end
        // Comments never count as lines; empty lines skip these checks
        if (!w.line_empty) begin
            if (w.first_char == CHAR_COMMENT) return RT_COMMENT;
            if (w.first_char == CHAR_BLOCK) begin
                in_block = !in_block;
                return RT_BLOCK;
            end
            if (in_block) return RT_BLOCK;
        end
        if (line_count < COUNT_MAX) line_count++;
        if (line_count <= HEADER_LINES) return RT_HEADER_BASE + line_count;
        if (w.line_empty) return RT_EMPTY;
        // Headers run on until the first attributes line
        if (w.first_char != CHAR_ATTR && !attr_seen) return RT_HEADER_LAST;
        if (end_seen && w.first_char != CHAR_END) return RT_ENDTEXT;
        t = char_record(w.first_char);
        if (t == RT_END) end_seen = 1'b1;
        if (t == RT_ATTRIBUTES) attr_seen = 1'b1;
        return t;
    endfunction

    // Printable byte that cannot toggle a comment block
    function automatic logic [7:0] text_char();
        logic [7:0] c;
        c = 8'($urandom_range(126, 32));
        return (c == CHAR_BLOCK) ? "x" : c;
    endfunction

    task automatic push_line(input bit start, input bit blank, input logic [7:0] ch);
        queued_line_t q;
        q.line.file_start = start;
        q.line.line_empty = blank;
        q.line.first_char = ch;
        q.drain           = drain_next;
        drain_next        = 1'b0;
        line_queue        = {line_queue, q};
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [4:0] want);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("tb: %s at %0t: record_type expected %0d, got %0d (tdata 0x%02h)",
                     what, $time, want, got[4:0], got);
    endtask

    // Drive words from the queue; predict each record as its word is taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                record_queue = {record_queue,
                                predict_record({s_tuser[0], s_tuser[1], s_tdata})};
                lines_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (line_queue.size() != 0
                    && !(line_queue[0].drain && record_queue.size() != 0)
                    && ($urandom_range(99) >= 34 || (lines_sent >= 400 && lines_sent < 600))) begin
                    s_tuser  <= {line_queue[0].line.line_empty, line_queue[0].line.file_start};
                    s_tdata  <= line_queue[0].line.first_char;
                    s_tvalid <= 1'b1;
                    void'(line_queue.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Check each record word against the oldest prediction
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (record_queue.size() == 0) begin
                    report_mismatch("record with none pending", m_tdata, 5'bx);
                end else begin
                    if (m_tdata !== {3'b000, record_queue[0]})
                        report_mismatch("mismatch", m_tdata, record_queue[0]);
                    void'(record_queue.pop_front());
                end
                records_checked++;
            end
            m_tready <= $urandom_range(99) >= 34
                        || (records_checked >= 400 && records_checked < 600);
        end
    end

    initial begin
        int shape;
        int pick;
        int k;
        int j;

        // Directed file: comments and a block inside the header window
        push_line(1'b1, 1'b0, CHAR_COMMENT);
        push_line(1'b0, 1'b1, 8'hFF);          // empty header line
        push_line(1'b0, 1'b0, CHAR_BLOCK);     // open block
        push_line(1'b0, 1'b0, "A");
        push_line(1'b0, 1'b1, CHAR_BLOCK);     // empty line inside block counts
        push_line(1'b0, 1'b0, CHAR_BLOCK);     // close block
        push_line(1'b0, 1'b0, 8'h00);
        push_line(1'b0, 1'b0, 8'hFF);
        push_line(1'b0, 1'b0, CHAR_ATTR);      // still a header line
        push_line(1'b0, 1'b0, CHAR_END);
        push_line(1'b0, 1'b0, "G");
        push_line(1'b0, 1'b0, 8'h7F);
        push_line(1'b0, 1'b0, 8'h80);
        push_line(1'b0, 1'b0, "r");
        push_line(1'b0, 1'b0, "c");            // eleventh header
        push_line(1'b0, 1'b0, "A");            // header 12 until attributes
        push_line(1'b0, 1'b1, 8'h00);          // empty after headers
        push_line(1'b0, 1'b0, CHAR_ATTR);
        push_line(1'b0, 1'b0, "*");
        push_line(1'b0, 1'b0, 8'hFF);          // unknown byte
        push_line(1'b0, 1'b0, CHAR_END);
        push_line(1'b0, 1'b0, "m");            // trailing text
        push_line(1'b0, 1'b0, CHAR_END);       // end mark again
        push_line(1'b1, 1'b0, "B");            // new file clears state
        file_count = 2;

        // Random files; every eighth waits for all records to drain first
        drain_next = 1'b1;
        while (line_queue.size() < 1000) begin
            file_count++;
            shape = $urandom_range(9);
            if (file_count % 8 == 0) drain_next = 1'b1;
            if (shape == 0) begin
                // Noise: any byte, random emptiness and file starts
                repeat ($urandom_range(20, 1))
                    push_line($urandom_range(9) == 0, 1'($urandom_range(1)),
                              8'($urandom_range(255)));
            end else begin
                // Header section; shape 1 carries state over from the last file
                push_line(shape != 1, 1'b0, text_char());
                for (k = 1; k < 12 + $urandom_range(3); k++) begin
                    pick = $urandom_range(99);
                    if (pick < 10) begin
                        push_line(1'b0, 1'b1, 8'($urandom_range(255)));
                    end else if (pick < 18) begin
                        push_line(1'b0, 1'b0, CHAR_COMMENT);
                    end else if (pick < 24) begin
                        push_line(1'b0, 1'b0, CHAR_BLOCK);
                        for (j = 0; j < $urandom_range(3, 1); j++)
                            push_line(1'b0, $urandom_range(3) == 0, 8'($urandom_range(255)));
                        push_line(1'b0, 1'b0, CHAR_BLOCK);
                    end else begin
                        push_line(1'b0, 1'b0, text_char());
                    end
                end
                // Shape 2 leaves out the attributes line after the headers
                if (shape != 2) push_line(1'b0, 1'b0, CHAR_ATTR);
                for (k = 0; k < $urandom_range(40, 4); k++) begin
                    pick = $urandom_range(99);
                    if (pick < 70) begin
                        push_line(1'b0, 1'b0, body_chars[$urandom_range(19)]);
                    end else if (pick < 76) begin
                        push_line(1'b0, 1'b1, 8'($urandom_range(255)));
                    end else if (pick < 80) begin
                        push_line(1'b0, 1'b0, CHAR_COMMENT);
                    end else if (pick < 85) begin
                        push_line(1'b0, 1'b0, CHAR_BLOCK);
                        for (j = 0; j < $urandom_range(3, 1); j++)
                            push_line(1'b0, $urandom_range(3) == 0, 8'($urandom_range(255)));
                        push_line(1'b0, 1'b0, CHAR_BLOCK);
                    end else if (pick < 90) begin
                        push_line(1'b0, 1'b0, 8'($urandom_range(255)));
                    end else begin
                        push_line(1'b0, 1'b0, text_char());
                    end
                end
                // End mark and trailing text, left out for shape 3
                if (shape != 3) begin
                    push_line(1'b0, 1'b0, CHAR_END);
                    for (k = 0; k < $urandom_range(6); k++) begin
                        pick = $urandom_range(9);
                        if (pick == 0)
                            push_line(1'b0, 1'b0, CHAR_END);
                        else if (pick == 1)
                            push_line(1'b0, 1'b1, 8'($urandom_range(255)));
                        else
                            push_line(1'b0, 1'b0, text_char());
                    end
                end
            end
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait for the last word to be taken and every record to return
        while (line_queue.size() != 0 || s_tvalid) @(posedge aclk);
        while (record_queue.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (record_queue.size() != 0) begin
            mismatch_count += record_queue.size();
            $display("tb: %0d records never arrived", record_queue.size());
        end
        $display("tb: %0d lines in %0d files (headers, blocks, body, end marks, noise)",
                 lines_sent, file_count);
        $display("tb: %0d records checked with random idles, %0d mismatches",
                 records_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #1000000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== music_record_line_classifier_top.f =====
design/mrlc_pkg.sv
design/mrlc_in_stage.sv
design/mrlc_classifier.sv
design/music_record_line_classifier_top.sv
tb/testbench.sv
